// ===== design/ric_pkg.sv =====
// Shared types, widths and codes for the reference-counted inode cache.
package ric_pkg;

  localparam int NUM_SLOTS_DEF = 64;

  localparam int DEV_W  = 16;
  localparam int INO_W  = 32;
  localparam int REF_W  = 16;
  localparam int HDL_W  = 6;
  localparam int BLK_W  = 32;
  localparam int OFF_W  = 3;
  localparam int STAT_W = 3;
  localparam int TBL_W  = 16;

  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 112;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  localparam logic [STAT_W-1:0] ST_HIT   = 3'd0;
  localparam logic [STAT_W-1:0] ST_ALLOC = 3'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 3'd2;
  localparam logic [STAT_W-1:0] ST_HELD  = 3'd3;
  localparam logic [STAT_W-1:0] ST_WB    = 3'd4;
  localparam logic [STAT_W-1:0] ST_ERR   = 3'd5;

  localparam logic [1:0] CMD_NONE  = 2'd0;
  localparam logic [1:0] CMD_INC   = 2'd1;
  localparam logic [1:0] CMD_ALLOC = 2'd2;
  localparam logic [1:0] CMD_DEC   = 2'd3;

  localparam logic [REF_W-1:0] REF_MAX = {REF_W{1'b1}};

  // broadcast to every cell: lookup key plus the update for the selected one
  typedef struct packed {
    logic [1:0]       kind;
    logic [DEV_W-1:0] dev;
    logic [INO_W-1:0] ino;
    logic             mark;
  } cell_cmd_t;

  // handed from each cell to its upper neighbor
  typedef struct packed {
    logic any_hit;
    logic any_free;
  } cell_chain_t;

  // per-cell lookup flags
  typedef struct packed {
    logic first_hit;
    logic first_free;
  } cell_flags_t;

endpackage

// ===== design/ric_cell.sv =====
// One inode slot: tag, reference count and dirty bit, with local match and free detect.
module ric_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ric_pkg::cell_cmd_t          cmd,
  input  logic                        sel,
  input  ric_pkg::cell_chain_t        chain_in,
  output ric_pkg::cell_chain_t        chain_out,
  output ric_pkg::cell_flags_t        flags,
  output logic [ric_pkg::DEV_W-1:0]   dev,
  output logic [ric_pkg::INO_W-1:0]   ino,
  output logic [ric_pkg::REF_W-1:0]   refs,
  output logic                        dirty
);

  logic [ric_pkg::DEV_W-1:0] dev_r;
  logic [ric_pkg::INO_W-1:0] ino_r;
  logic [ric_pkg::REF_W-1:0] refs_r;
  logic                      dirty_r;
  logic                      match;
  logic                      free;

  // a zero inode tag never matches, so a reset (empty) slot cannot hit
  assign match = (ino_r != '0) && (ino_r == cmd.ino) && (dev_r == cmd.dev);
  assign free  = (refs_r == '0);

  assign flags.first_hit  = match & ~chain_in.any_hit;
  assign flags.first_free = free & ~chain_in.any_free;
  assign chain_out.any_hit  = chain_in.any_hit | match;
  assign chain_out.any_free = chain_in.any_free | free;

  assign dev   = dev_r;
  assign ino   = ino_r;
  assign refs  = refs_r;
  assign dirty = dirty_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_r   <= '0;
      ino_r   <= '0;
      refs_r  <= '0;
      dirty_r <= 1'b0;
    end else if (sel) begin
      unique case (cmd.kind)
        ric_pkg::CMD_INC: begin
          if (refs_r != ric_pkg::REF_MAX) refs_r <= refs_r + 1'b1;
        end
        ric_pkg::CMD_ALLOC: begin
          dev_r   <= cmd.dev;
          ino_r   <= cmd.ino;
          refs_r  <= {{(ric_pkg::REF_W-1){1'b0}}, 1'b1};
          dirty_r <= 1'b0;
        end
        ric_pkg::CMD_DEC: begin
          refs_r  <= refs_r - 1'b1;
          dirty_r <= dirty_r | cmd.mark;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== design/refcounted_inode_cache.sv =====
// Top level of the reference-counted inode cache: request stage, cell row, result register.
//
// Input words (in_*) carry a get (in_tuser = 0) or a put (in_tuser = 1). A get looks up
// device and inode in every slot at once; a hit bumps the count, a miss claims the lowest
// free slot and returns the disk block and offset to load, and a table with no free slot
// reports full. A put releases a slot and may return a write-back request.
// Result words (out_*) carry the status in out_tuser and the slot fields in out_tdata.
// While results are taken, one word is accepted every cycle: the request register is
// followed by an evaluate step in which the cell row compares, the priority chain through
// the cells picks a slot, and the chosen cell updates. The lookup of the next word sees
// the update, so back-to-back words on one slot are fine.
// cfg_we writes the inode table start block; write it only while no word is in flight.
// Reset clears every slot (count zero, empty tag), the table start and both stages.
// When the receiver stalls, the result word holds and one further word is taken into the
// request register; after that in_tready stays low until the result is taken.
module refcounted_inode_cache #(
  parameter int NUM_SLOTS = ric_pkg::NUM_SLOTS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // device_id[15:0], inode_number[47:16], slot_handle[53:48], dirty_mark[54], zero[55]
  input  logic [ric_pkg::IN_DATA_W-1:0]    in_tdata,
  // operation[0]
  input  logic                             in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // slot_index[5:0], disk_block[37:6], block_offset[40:38], entry_device[56:41],
  // entry_inode[88:57], ref_count_out[104:89], zero[111:105]
  output logic [ric_pkg::OUT_DATA_W-1:0]   out_tdata,
  // status[2:0]
  output logic [ric_pkg::STAT_W-1:0]       out_tuser,
  input  logic                             cfg_we,
  input  logic [ric_pkg::TBL_W-1:0]        cfg_wdata
);

  localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  // request stage
  logic                        req_valid_r;
  logic                        req_op_r;
  logic [ric_pkg::DEV_W-1:0]   req_dev_r;
  logic [ric_pkg::INO_W-1:0]   req_ino_r;
  logic [ric_pkg::HDL_W-1:0]   req_h_r;
  logic                        req_mark_r;
  logic [ric_pkg::TBL_W-1:0]   tbl_start_r;

  // result stage
  logic                        out_valid_r;
  logic [ric_pkg::STAT_W-1:0]  res_stat_r;
  logic [ric_pkg::HDL_W-1:0]   res_slot_r;
  logic [ric_pkg::BLK_W-1:0]   res_blk_r;
  logic [ric_pkg::OFF_W-1:0]   res_off_r;
  logic [ric_pkg::DEV_W-1:0]   res_dev_r;
  logic [ric_pkg::INO_W-1:0]   res_ino_r;
  logic [ric_pkg::REF_W-1:0]   res_refs_r;

  logic                        fire;

  ric_pkg::cell_cmd_t          cmd;
  ric_pkg::cell_chain_t        chain [NUM_SLOTS+1];
  ric_pkg::cell_flags_t        flags [NUM_SLOTS];
  logic [ric_pkg::DEV_W-1:0]   cell_dev  [NUM_SLOTS];
  logic [ric_pkg::INO_W-1:0]   cell_ino  [NUM_SLOTS];
  logic [ric_pkg::REF_W-1:0]   cell_refs [NUM_SLOTS];
  logic                        cell_dirty [NUM_SLOTS];
  logic [NUM_SLOTS-1:0]        sel_oh;

  logic [SLOT_W-1:0]           sel_idx;
  logic [ric_pkg::DEV_W-1:0]   rd_dev;
  logic [ric_pkg::INO_W-1:0]   rd_ino;
  logic [ric_pkg::REF_W-1:0]   rd_refs;
  logic                        rd_dirty;
  logic                        h_ok;
  logic [ric_pkg::INO_W-1:0]   place_z;
  logic [ric_pkg::REF_W-1:0]   dec_refs;
  logic                        dec_dirty;

  logic [ric_pkg::STAT_W-1:0]  res_stat_nxt;
  logic [ric_pkg::HDL_W-1:0]   res_slot_nxt;
  logic [ric_pkg::BLK_W-1:0]   res_blk_nxt;
  logic [ric_pkg::OFF_W-1:0]   res_off_nxt;
  logic [ric_pkg::DEV_W-1:0]   res_dev_nxt;
  logic [ric_pkg::INO_W-1:0]   res_ino_nxt;
  logic [ric_pkg::REF_W-1:0]   res_refs_nxt;

  assign fire      = req_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !req_valid_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
      tbl_start_r <= '0;
    end else begin
      if (in_tvalid && in_tready) req_valid_r <= 1'b1;
      else if (fire)              req_valid_r <= 1'b0;
      if (cfg_we) tbl_start_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      req_op_r   <= in_tuser;
      req_dev_r  <= in_tdata[15:0];
      req_ino_r  <= in_tdata[47:16];
      req_h_r    <= in_tdata[53:48];
      req_mark_r <= in_tdata[54];
    end
  end

  // cell row; the any-hit / any-free chain ripples from slot 0 upward
  assign chain[0] = '0;

  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
    ric_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd),
      .sel       (fire & sel_oh[i]),
      .chain_in  (chain[i]),
      .chain_out (chain[i+1]),
      .flags     (flags[i]),
      .dev       (cell_dev[i]),
      .ino       (cell_ino[i]),
      .refs      (cell_refs[i]),
      .dirty     (cell_dirty[i])
    );
  end

  assign h_ok = int'(req_h_r) < NUM_SLOTS;

  // slot select and readout
  always_comb begin
    sel_oh   = '0;
    sel_idx  = '0;
    rd_dev   = '0;
    rd_ino   = '0;
    rd_refs  = '0;
    rd_dirty = 1'b0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (req_op_r == ric_pkg::OP_PUT) sel_oh[i] = (int'(req_h_r) == i);
      else if (chain[NUM_SLOTS].any_hit) sel_oh[i] = flags[i].first_hit;
      else sel_oh[i] = flags[i].first_free;
    end
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (sel_oh[i]) sel_idx = sel_idx | SLOT_W'(i);
      rd_dev   = rd_dev   | ({ric_pkg::DEV_W{sel_oh[i]}} & cell_dev[i]);
      rd_ino   = rd_ino   | ({ric_pkg::INO_W{sel_oh[i]}} & cell_ino[i]);
      rd_refs  = rd_refs  | ({ric_pkg::REF_W{sel_oh[i]}} & cell_refs[i]);
      rd_dirty = rd_dirty | (sel_oh[i] & cell_dirty[i]);
    end
  end

  assign dec_refs  = rd_refs - 1'b1;
  assign dec_dirty = rd_dirty | req_mark_r;

  // command to the selected cell, and the result word
  always_comb begin
    cmd.dev  = req_dev_r;
    cmd.ino  = req_ino_r;
    cmd.mark = req_mark_r;
    cmd.kind = ric_pkg::CMD_NONE;
    place_z  = req_ino_r - 1'b1;

    res_stat_nxt = ric_pkg::ST_ERR;
    res_slot_nxt = '0;
    res_blk_nxt  = '0;
    res_off_nxt  = '0;
    res_dev_nxt  = '0;
    res_ino_nxt  = '0;
    res_refs_nxt = '0;

    if (req_op_r == ric_pkg::OP_GET) begin
      if (chain[NUM_SLOTS].any_hit) begin
        cmd.kind     = ric_pkg::CMD_INC;
        res_stat_nxt = ric_pkg::ST_HIT;
        res_slot_nxt = ric_pkg::HDL_W'(sel_idx);
        res_dev_nxt  = rd_dev;
        res_ino_nxt  = rd_ino;
        res_refs_nxt = (rd_refs == ric_pkg::REF_MAX) ? rd_refs : rd_refs + 1'b1;
      end else if (chain[NUM_SLOTS].any_free) begin
        cmd.kind     = ric_pkg::CMD_ALLOC;
        res_stat_nxt = ric_pkg::ST_ALLOC;
        res_slot_nxt = ric_pkg::HDL_W'(sel_idx);
        res_dev_nxt  = req_dev_r;
        res_ino_nxt  = req_ino_r;
        res_refs_nxt = {{(ric_pkg::REF_W-1){1'b0}}, 1'b1};
        res_blk_nxt  = {3'b000, place_z[31:3]} + {16'h0000, tbl_start_r};
        res_off_nxt  = place_z[2:0];
      end else begin
        res_stat_nxt = ric_pkg::ST_FULL;
      end
    end else begin
      res_slot_nxt = req_h_r;
      if (h_ok) begin
        res_dev_nxt = rd_dev;
        res_ino_nxt = rd_ino;
        if (rd_refs != '0) begin
          cmd.kind     = ric_pkg::CMD_DEC;
          res_refs_nxt = dec_refs;
          place_z      = rd_ino - 1'b1;
          if (dec_refs == '0 && dec_dirty) begin
            res_stat_nxt = ric_pkg::ST_WB;
            res_blk_nxt  = {3'b000, place_z[31:3]} + {16'h0000, tbl_start_r};
            res_off_nxt  = place_z[2:0];
          end else begin
            res_stat_nxt = ric_pkg::ST_HELD;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_stat_r <= res_stat_nxt;
      res_slot_r <= res_slot_nxt;
      res_blk_r  <= res_blk_nxt;
      res_off_r  <= res_off_nxt;
      res_dev_r  <= res_dev_nxt;
      res_ino_r  <= res_ino_nxt;
      res_refs_r <= res_refs_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = res_stat_r;
  assign out_tdata  = {7'b0000000, res_refs_r, res_ino_r, res_dev_r, res_off_r,
                       res_blk_r, res_slot_r};

endmodule

// ===== design/ric_checker.sv =====
// Port-level checks for the inode cache, bound to the top level.
module ric_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [ric_pkg::OUT_DATA_W-1:0]  out_tdata,
  input logic [ric_pkg::STAT_W-1:0]      out_tuser
);

  // a stalled result word stays valid
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result word dropped while stalled");

  // full table reports nothing but the status
  a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ric_pkg::ST_FULL |-> out_tdata == '0)
    else $error("full result carries payload");

  // a freshly claimed slot holds exactly one reference
  a_alloc_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ric_pkg::ST_ALLOC |-> out_tdata[104:89] == 16'd1)
    else $error("allocation count not one");

  // write-back only when the last reference goes away
  a_wb_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ric_pkg::ST_WB |-> out_tdata[104:89] == 16'd0)
    else $error("write-back with references held");

endmodule

bind refcounted_inode_cache ric_checker u_ric_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ===== sim/refcounted_inode_cache_tb.sv =====
// Self-checking testbench for the reference-counted inode cache: directed table, then random words.
module refcounted_inode_cache_tb;
  import ric_pkg::*;

  localparam int SLOTS       = NUM_SLOTS_DEF;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASES      = 10;
  localparam int PHASE_WORDS = 175;
  localparam int POOL        = 96;
  localparam int N_DIR       = 20;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [HDL_W-1:0]  slot;
    logic [BLK_W-1:0]  blk;
    logic [OFF_W-1:0]  off;
    logic [DEV_W-1:0]  dev;
    logic [INO_W-1:0]  ino;
    logic [REF_W-1:0]  refs;
  } inode_reply_t;

  typedef struct packed {
    logic             op;
    logic [DEV_W-1:0] dev;
    logic [INO_W-1:0] ino;
    logic [HDL_W-1:0] hdl;
    logic             mark;
    logic             has_exp;
    inode_reply_t     exp;
  } dir_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [STAT_W-1:0]     out_tuser;
  logic                  cfg_we = 1'b0;
  logic [TBL_W-1:0]      cfg_wdata = '0;

  // shadow copy of the cache
  logic [TBL_W-1:0] tbl_start;
  logic [DEV_W-1:0] dev_tab [SLOTS];
  logic [INO_W-1:0] ino_tab [SLOTS];
  logic [REF_W-1:0] ref_tab [SLOTS];
  logic             dirty_tab [SLOTS];

  inode_reply_t pending_replies [$];
  int           errors = 0;
  logic         quiet = 1'b0;
  int           hold_requests = 0;
  int           holds_served = 0;
  int           stall_left = 0;

  logic [DEV_W-1:0] pool_dev [POOL];
  logic [INO_W-1:0] pool_ino [POOL];
  dir_row_t         dir_rows [N_DIR];

  refcounted_inode_cache #(.NUM_SLOTS(SLOTS)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #12_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic void place_of(input logic [INO_W-1:0] ino, output logic [BLK_W-1:0] blk,
                                   output logic [OFF_W-1:0] off);
    logic [INO_W-1:0] z;
    z = ino - 1'b1;
    blk = (z >> 3) + {16'd0, tbl_start};
    off = z[OFF_W-1:0];
  endfunction

  function automatic inode_reply_t tag_of(input logic [STAT_W-1:0] st, input int s);
    inode_reply_t r;
    r = '{st, s[HDL_W-1:0], '0, '0, dev_tab[s], ino_tab[s], ref_tab[s]};
    return r;
  endfunction

  // updates the shadow cache for one word and returns the reply it should produce
  function automatic inode_reply_t cache_reply(input logic op, input logic [DEV_W-1:0] dev,
                                               input logic [INO_W-1:0] ino,
                                               input logic [HDL_W-1:0] hdl, input logic mark);
    inode_reply_t r;
    int hit, fre;
    hit = -1;
    fre = -1;
    r = '0;
    if (op == OP_GET) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (hit < 0 && ino_tab[i] != 0 && ino_tab[i] == ino && dev_tab[i] == dev) hit = i;
        if (fre < 0 && ref_tab[i] == 0) fre = i;
      end
      if (hit >= 0) begin
        if (ref_tab[hit] != REF_MAX) ref_tab[hit] = ref_tab[hit] + 1'b1;
        r = tag_of(ST_HIT, hit);
      end else if (fre >= 0) begin
        ref_tab[fre] = REF_W'(1);
        dev_tab[fre] = dev;
        ino_tab[fre] = ino;
        dirty_tab[fre] = 1'b0;
        r = tag_of(ST_ALLOC, fre);
        place_of(ino, r.blk, r.off);
      end else begin
        r.status = ST_FULL;
      end
    end else if (int'(hdl) >= SLOTS) begin
      r.status = ST_ERR;
      r.slot = hdl;
    end else if (ref_tab[hdl] == 0) begin
      r = tag_of(ST_ERR, hdl);
    end else begin
      dirty_tab[hdl] = dirty_tab[hdl] | mark;
      ref_tab[hdl] = ref_tab[hdl] - 1'b1;
      if (ref_tab[hdl] == 0 && dirty_tab[hdl]) begin
        r = tag_of(ST_WB, hdl);
        place_of(ino_tab[hdl], r.blk, r.off);
      end else begin
        r = tag_of(ST_HELD, hdl);
      end
    end
    return r;
  endfunction

  task automatic send_word(input logic op, input logic [DEV_W-1:0] dev,
                           input logic [INO_W-1:0] ino, input logic [HDL_W-1:0] hdl,
                           input logic mark, input logic has_exp, input inode_reply_t typed);
    inode_reply_t want;
    while (!quiet && $urandom_range(99) < 13) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {1'b0, mark, hdl, ino, dev};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    want = cache_reply(op, dev, ino, hdl, mark);
    if (has_exp) want = typed;
    pending_replies.push_back(want);
  endtask

  // block idle: all replies in, pipeline drained
  task automatic set_table_start(input logic [TBL_W-1:0] v);
    in_tvalid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    tbl_start = v;
  endtask

  task automatic random_word(input int get_pct);
    logic [DEV_W-1:0] dev;
    logic [INO_W-1:0] ino;
    logic [HDL_W-1:0] hdl;
    logic             mark;
    int               k, start, pick;
    dev = DEV_W'($urandom_range(65535));
    ino = $urandom();
    hdl = HDL_W'($urandom_range(63));
    mark = 1'($urandom_range(1));
    pick = -1;
    if ($urandom_range(99) < 15) begin
      // noise: arbitrary key, or a put on any handle
      if ($urandom_range(7) == 0) ino = '0;
      send_word(1'($urandom_range(1)), dev, ino, hdl, mark, 1'b0, '0);
    end else begin
      if ($urandom_range(99) >= get_pct) begin
        start = $urandom_range(SLOTS - 1);
        for (int j = 0; j < SLOTS; j++) begin
          k = (start + j) % SLOTS;
          if (pick < 0 && ref_tab[k] != 0) pick = k;
        end
      end
      if (pick >= 0) begin
        send_word(OP_PUT, dev, ino, pick[HDL_W-1:0], mark, 1'b0, '0);
      end else begin
        k = $urandom_range(POOL - 1);
        send_word(OP_GET, pool_dev[k], pool_ino[k], hdl, mark, 1'b0, '0);
      end
    end
  endtask

  // receiver: random backpressure plus one long hold on request
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (holds_served != hold_requests) begin
      holds_served <= holds_served + 1;
      stall_left <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= quiet || ($urandom_range(99) >= 13);
    end
  end

  always @(posedge clk) begin : reply_check
    inode_reply_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{out_tuser, out_tdata[5:0], out_tdata[37:6], out_tdata[40:38], out_tdata[56:41],
              out_tdata[88:57], out_tdata[104:89]};
      if (pending_replies.size() == 0) begin
        if (errors < 10)
          $display("ERROR: unexpected reply st=%0d slot=%0d", got.status, got.slot);
        errors = errors + 1;
      end else begin
        want = pending_replies.pop_front();
        if (got.status != want.status || got.slot != want.slot || got.blk != want.blk ||
            got.off != want.off || got.dev != want.dev || got.ino != want.ino ||
            got.refs != want.refs || out_tdata[111:105] != '0) begin
          if (errors < 10) begin
            $display("ERROR: exp st=%0d slot=%0d blk=%h off=%0d dev=%h ino=%h refs=%0d",
                     want.status, want.slot, want.blk, want.off, want.dev, want.ino,
                     want.refs);
            $display("       got st=%0d slot=%0d blk=%h off=%0d dev=%h ino=%h refs=%0d pad=%h",
                     got.status, got.slot, got.blk, got.off, got.dev, got.ino, got.refs,
                     out_tdata[111:105]);
          end
          errors = errors + 1;
        end
      end
    end
  end

  initial begin : stimulus
    logic [TBL_W-1:0] starts [PHASES];
    int               get_pcts [PHASES];
    tbl_start = '0;
    for (int i = 0; i < SLOTS; i++) begin
      dev_tab[i] = '0;
      ino_tab[i] = '0;
      ref_tab[i] = '0;
      dirty_tab[i] = 1'b0;
    end
    // small devices in three of four entries and small inode numbers in half, so keys repeat
    for (int i = 0; i < POOL; i++) begin
      pool_dev[i] = (i % 4 == 0) ? 16'($urandom_range(65535)) : 16'($urandom_range(3));
      pool_ino[i] = (i % 2 == 0) ? $urandom_range(32'hFFFFFFFF, 1) : $urandom_range(200, 1);
    end
    pool_dev[0] = '0;
    pool_ino[0] = 32'd1;
    pool_dev[1] = 16'hFFFF;
    pool_ino[1] = 32'hFFFFFFFF;

    dir_rows[0]  = '{OP_PUT, 16'h0000, 32'h00000000, 6'd0, 1'b0, 1'b1,
                     '{ST_ERR, 6'd0, 32'd0, 3'd0, 16'h0000, 32'h00000000, 16'd0}};
    dir_rows[1]  = '{OP_PUT, 16'hFFFF, 32'hFFFFFFFF, 6'd63, 1'b1, 1'b1,
                     '{ST_ERR, 6'd63, 32'd0, 3'd0, 16'h0000, 32'h00000000, 16'd0}};
    dir_rows[2]  = '{OP_GET, 16'h0000, 32'h00000001, 6'd0, 1'b0, 1'b1,
                     '{ST_ALLOC, 6'd0, 32'd0, 3'd0, 16'h0000, 32'h00000001, 16'd1}};
    dir_rows[3]  = '{OP_GET, 16'hFFFF, 32'hFFFFFFFF, 6'd0, 1'b0, 1'b1,
                     '{ST_ALLOC, 6'd1, 32'h1FFFFFFF, 3'd6, 16'hFFFF, 32'hFFFFFFFF, 16'd1}};
    // inode zero never hits: two allocations, offset 7
    dir_rows[4]  = '{OP_GET, 16'h0000, 32'h00000000, 6'd0, 1'b0, 1'b1,
                     '{ST_ALLOC, 6'd2, 32'h1FFFFFFF, 3'd7, 16'h0000, 32'h00000000, 16'd1}};
    dir_rows[5]  = '{OP_GET, 16'h0000, 32'h00000000, 6'd0, 1'b0, 1'b1,
                     '{ST_ALLOC, 6'd3, 32'h1FFFFFFF, 3'd7, 16'h0000, 32'h00000000, 16'd1}};
    dir_rows[6]  = '{OP_GET, 16'h0000, 32'h00000001, 6'd0, 1'b0, 1'b1,
                     '{ST_HIT, 6'd0, 32'd0, 3'd0, 16'h0000, 32'h00000001, 16'd2}};
    dir_rows[7]  = '{OP_GET, 16'h0001, 32'h00000001, 6'd0, 1'b0, 1'b0, '0};
    dir_rows[8]  = '{OP_GET, 16'hFFFF, 32'hFFFFFFFF, 6'd0, 1'b0, 1'b0, '0};
    dir_rows[9]  = '{OP_PUT, 16'h0000, 32'h00000000, 6'd0, 1'b1, 1'b0, '0};
    dir_rows[10] = '{OP_PUT, 16'h0000, 32'h00000000, 6'd0, 1'b0, 1'b0, '0};
    // hit on a zero-count slot, dirty still set so the next release writes back again
    dir_rows[11] = '{OP_GET, 16'h0000, 32'h00000001, 6'd0, 1'b0, 1'b0, '0};
    dir_rows[12] = '{OP_PUT, 16'h0000, 32'h00000000, 6'd0, 1'b0, 1'b0, '0};
    dir_rows[13] = '{OP_PUT, 16'h0000, 32'h00000000, 6'd0, 1'b0, 1'b0, '0};
    // reclaim clears dirty
    dir_rows[14] = '{OP_GET, 16'h0005, 32'h00000009, 6'd0, 1'b0, 1'b0, '0};
    dir_rows[15] = '{OP_PUT, 16'h0000, 32'h00000000, 6'd0, 1'b0, 1'b0, '0};
    dir_rows[16] = '{OP_PUT, 16'h0000, 32'h00000000, 6'd2, 1'b0, 1'b0, '0};
    dir_rows[17] = '{OP_GET, 16'h8000, 32'h80000000, 6'd63, 1'b1, 1'b0, '0};
    dir_rows[18] = '{OP_PUT, 16'h0000, 32'h00000000, 6'd1, 1'b1, 1'b0, '0};
    dir_rows[19] = '{OP_PUT, 16'h0000, 32'h00000000, 6'd1, 1'b0, 1'b0, '0};

    starts = '{16'hFFFF, 16'h0000, 16'h0000, 16'h0001, 16'h0000,
               16'h8000, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000};
    get_pcts = '{95, 60, 30, 95, 70, 20, 90, 50, 80, 40};
    for (int p = 0; p < PHASES; p++)
      if (starts[p] == 16'h0000 && p % 2 == 0) starts[p] = TBL_W'($urandom_range(65535));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < N_DIR; r++)
      send_word(dir_rows[r].op, dir_rows[r].dev, dir_rows[r].ino, dir_rows[r].hdl,
                dir_rows[r].mark, dir_rows[r].has_exp, dir_rows[r].exp);

    for (int p = 0; p < PHASES; p++) begin
      set_table_start(starts[p]);
      quiet = (p == 2);
      if (p == 3) hold_requests = hold_requests + 1;
      for (int n = 0; n < PHASE_WORDS; n++) random_word(get_pcts[p]);
    end
    quiet = 1'b0;
    in_tvalid <= 1'b0;

    while (pending_replies.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
